[rtl/hcfs_pkg.sv]
// ----------------------------------------------------------------------------
// hcfs_pkg
// Shared types and codes for the health-checked failover selector.
// ----------------------------------------------------------------------------
package hcfs_pkg;

   // Request operation codes
   localparam logic OP_PROBE  = 1'b0;
   localparam logic OP_DECIDE = 1'b1;

   // Decision action codes
   localparam logic [2:0] ACT_CONTINUE = 3'd0;
   localparam logic [2:0] ACT_FAILBACK = 3'd1;
   localparam logic [2:0] ACT_GRACE    = 3'd2;
   localparam logic [2:0] ACT_FAILOVER = 3'd3;
   localparam logic [2:0] ACT_NONE     = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] CSR_OK_THRESHOLD   = 2'd0;
   localparam logic [1:0] CSR_FAIL_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_ENTRY_COUNT    = 2'd2;

   // Field widths fixed by the interface
   localparam int ENTRY_W  = 4;
   localparam int THRESH_W = 8;
   localparam int ECOUNT_W = 5;
   localparam int ACTION_W = 3;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE_WR,
      ST_DEC_EVAL,
      ST_SCAN
   } state_type;

endpackage

[rtl/health_checked_failover_selector.sv]
// ----------------------------------------------------------------------------
// health_checked_failover_selector
// Failover selector over redundant targets with per-entry ok and miss counts.
// ----------------------------------------------------------------------------
// Probe: read the entry row, then write it back in ST_PROBE_WR; a probe of
//   an entry outside the entry count is dropped and leaves the block idle.
// Decide: rsp_strobe when ST_DEC_EVAL settles it on the current entry; else
//   ST_SCAN scans up to the entry count, one counter-memory read per cycle.
// No result is ever held off: the receiver cannot stall.
// Reset clears all counts at once through per-entry valid bits, no sweep.
// ----------------------------------------------------------------------------
module health_checked_failover_selector
   import hcfs_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int COUNT_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_operation,
   input  logic [ENTRY_W-1:0]  req_entry,
   input  logic                req_probe_ok,
   output logic                rsp_strobe,
   output logic [ENTRY_W-1:0]  rsp_selected_entry,
   output logic [ACTION_W-1:0] rsp_action,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [THRESH_W-1:0] csr_wdata
);

   localparam int IW = $clog2(ENTRIES);
   localparam int NW = $clog2(ENTRIES + 1);
   localparam int CW = (NW > ECOUNT_W) ? NW : ECOUNT_W;
   localparam int EW = (IW > ENTRY_W) ? IW : ENTRY_W;
   localparam int SW = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;

   state_type               state_ff, state_in;
   logic [THRESH_W-1:0]     ok_threshold_ff;
   logic [THRESH_W-1:0]     fail_threshold_ff;
   logic [ECOUNT_W-1:0]     entry_count_ff;
   logic [ENTRIES-1:0]      valid_ff;
   logic [IW-1:0]           rd_addr_ff;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [IW-1:0]           cur_ff, cur_in;
   logic [IW-1:0]           sel_ff, sel_in;
   logic [COUNT_BITS-1:0]   ok0_ff, ok0_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [ACTION_W-1:0]     rsp_action_ff, rsp_action_in;

   logic [CW-1:0]           n_eff;
   logic [CW-1:0]           ec_ext;
   logic [EW-1:0]           entry_ext;
   logic [EW-1:0]           sel_ext;
   logic [IW-1:0]           entry_addr;
   logic [IW-1:0]           cur_pick;
   logic                    entry_in_range;
   logic [IW-1:0]           rd_addr;
   logic                    wr_en;
   logic [2*COUNT_BITS-1:0] ram_q;
   logic [COUNT_BITS-1:0]   rd_ok;
   logic [COUNT_BITS-1:0]   rd_miss;
   logic [COUNT_BITS-1:0]   ok_next;
   logic [COUNT_BITS-1:0]   miss_next;
   logic                    failback;
   logic                    scan_last;
   logic                    probe_ok_ff;

   // Clamp the entry count to the range in use
   always_comb begin
      ec_ext = CW'(entry_count_ff);
      if (ec_ext == '0) begin
         n_eff = CW'(1);
      end else if (ec_ext > CW'(ENTRIES)) begin
         n_eff = CW'(ENTRIES);
      end else begin
         n_eff = ec_ext;
      end
   end

   assign entry_ext      = EW'(req_entry);
   assign entry_addr     = entry_ext[IW-1:0];
   assign entry_in_range = (CW'(req_entry) < n_eff);
   assign cur_pick       = (CW'(sel_ff) >= n_eff) ? '0 : sel_ff;

   // Mask rows that were never written since reset
   assign rd_ok   = valid_ff[rd_addr_ff] ? ram_q[2*COUNT_BITS-1:COUNT_BITS] : '0;
   assign rd_miss = valid_ff[rd_addr_ff] ? ram_q[COUNT_BITS-1:0] : '0;

   assign failback  = (cur_ff != '0) && (SW'(ok0_ff) >= SW'(ok_threshold_ff));
   assign scan_last = (CW'(idx_ff) == n_eff - CW'(1));

   // Counter memory: one row of {ok, miss} per entry
   hcfs_ram #(
      .WIDTH (2 * COUNT_BITS),
      .DEPTH (ENTRIES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (rd_addr_ff),
      .wr_data ({ok_next, miss_next}),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Saturating update of the row read for a probe
   hcfs_count #(
      .COUNT_BITS (COUNT_BITS)
   ) u_count (
      .probe_ok       (probe_ok_ff),
      .ok_count       (rd_ok),
      .miss_count     (rd_miss),
      .ok_threshold   (ok_threshold_ff),
      .fail_threshold (fail_threshold_ff),
      .ok_next        (ok_next),
      .miss_next      (miss_next)
   );

   // Advance the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state, memory access and decision
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      sel_in        = sel_ff;
      rsp_strobe_in = 1'b0;
      rsp_action_in = rsp_action_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_operation == OP_PROBE) begin
                  rd_addr = entry_addr;
                  if (entry_in_range) begin
                     state_in = ST_PROBE_WR;
                  end
               end else begin
                  rd_addr  = cur_pick;
                  cur_in   = cur_pick;
                  state_in = ST_DEC_EVAL;
               end
            end
         end
         ST_PROBE_WR: begin
            wr_en    = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DEC_EVAL: begin
            if (rd_ok != '0) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
               if (failback) begin
                  sel_in        = '0;
                  rsp_action_in = ACT_FAILBACK;
               end else begin
                  sel_in        = cur_ff;
                  rsp_action_in = ACT_CONTINUE;
               end
            end else if (SW'(rd_miss) <= SW'(fail_threshold_ff)) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
               sel_in        = cur_ff;
               rsp_action_in = ACT_GRACE;
            end else begin
               rd_addr  = '0;
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_addr = idx_ff + IW'(1);
            idx_in  = idx_ff + IW'(1);
            if (rd_ok != '0) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
               if (failback) begin
                  sel_in        = '0;
                  rsp_action_in = ACT_FAILBACK;
               end else begin
                  sel_in        = idx_ff;
                  rsp_action_in = ACT_FAILOVER;
               end
            end else if (scan_last) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
               sel_in        = '0;
               rsp_action_in = ACT_NONE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Mirror entry zero's ok count for fail-back checks
   always_comb begin
      ok0_in = ok0_ff;
      if (wr_en && (rd_addr_ff == '0)) begin
         ok0_in = ok_next;
      end
   end

   // Hold control state: selection, entry-zero ok mirror, valid bits, result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff        <= '0;
         ok0_ff        <= '0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         sel_ff        <= sel_in;
         ok0_ff        <= ok0_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (wr_en) begin
            valid_ff[rd_addr_ff] <= 1'b1;
         end
      end
   end

   // Capture working registers of the current transaction
   always_ff @(posedge clock) begin
      rd_addr_ff    <= rd_addr;
      idx_ff        <= idx_in;
      cur_ff        <= cur_in;
      rsp_action_ff <= rsp_action_in;
      if ((state_ff == ST_IDLE) && start) begin
         probe_ok_ff <= req_probe_ok;
      end
   end

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ok_threshold_ff   <= THRESH_W'(3);
         fail_threshold_ff <= THRESH_W'(3);
         entry_count_ff    <= ECOUNT_W'(16);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_OK_THRESHOLD:   ok_threshold_ff   <= csr_wdata;
            CSR_FAIL_THRESHOLD: fail_threshold_ff <= csr_wdata;
            CSR_ENTRY_COUNT:    entry_count_ff    <= csr_wdata[ECOUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Drive outputs
   assign sel_ext            = EW'(sel_ff);
   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_selected_entry = sel_ext[ENTRY_W-1:0];
   assign rsp_action         = rsp_action_ff;

endmodule

[rtl/hcfs_ram.sv]
// ----------------------------------------------------------------------------
// hcfs_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module hcfs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write the addressed row and register the read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[rtl/hcfs_count.sv]
// ----------------------------------------------------------------------------
// hcfs_count
// Counter update for one probe transaction: bump one count with saturation,
// clear the other.
// ----------------------------------------------------------------------------
module hcfs_count
   import hcfs_pkg::*;
#(
   parameter int COUNT_BITS = 8
) (
   input  logic                  probe_ok,
   input  logic [COUNT_BITS-1:0] ok_count,
   input  logic [COUNT_BITS-1:0] miss_count,
   input  logic [THRESH_W-1:0]   ok_threshold,
   input  logic [THRESH_W-1:0]   fail_threshold,
   output logic [COUNT_BITS-1:0] ok_next,
   output logic [COUNT_BITS-1:0] miss_next
);

   localparam int SW = (COUNT_BITS > THRESH_W + 1) ? COUNT_BITS : THRESH_W + 1;

   logic [SW-1:0] count_max;
   logic [SW-1:0] limit;
   logic [SW-1:0] thresh_p1;
   logic [SW-1:0] value;
   logic [SW-1:0] bumped;

   // Pick the counter and threshold that this probe bumps
   always_comb begin
      count_max = SW'({COUNT_BITS{1'b1}});
      if (probe_ok) begin
         thresh_p1 = SW'(ok_threshold) + SW'(1);
         value     = SW'(ok_count);
      end else begin
         thresh_p1 = SW'(fail_threshold) + SW'(1);
         value     = SW'(miss_count);
      end
      limit  = (thresh_p1 > count_max) ? count_max : thresh_p1;
      bumped = (value >= limit) ? limit : value + SW'(1);
   end

   // Clear the opposite counter
   always_comb begin
      if (probe_ok) begin
         ok_next   = bumped[COUNT_BITS-1:0];
         miss_next = '0;
      end else begin
         ok_next   = '0;
         miss_next = bumped[COUNT_BITS-1:0];
      end
   end

endmodule
